### design/pfc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pfc_pkg;

    // Key square geometry
    localparam int SIDE    = 5;
    localparam int CELLS   = SIDE * SIDE;
    localparam int LETTERS = 26;

    // Letter indexes (A = 0)
    localparam logic [4:0] LETTER_I = 5'd8;
    localparam logic [4:0] LETTER_J = 5'd9;
    localparam logic [4:0] LETTER_X = 5'd23;
    localparam logic [4:0] LAST_LETTER = 5'(LETTERS - 1);
    localparam logic [4:0] CELL_COUNT  = 5'(CELLS);

    // ASCII bounds
    localparam logic [7:0] ASCII_UP_A = 8'd65;
    localparam logic [7:0] ASCII_UP_Z = 8'd90;
    localparam logic [7:0] ASCII_LO_A = 8'd97;
    localparam logic [7:0] ASCII_LO_Z = 8'd122;
    localparam logic [6:0] CHAR_A     = 7'd65;

    // Item kinds on the input tuser
    typedef enum logic [2:0] {
        FUNC_START_KEY = 3'd0,
        FUNC_KEY_BYTE  = 3'd1,
        FUNC_KEY_END   = 3'd2,
        FUNC_TEXT_BYTE = 3'd3,
        FUNC_TEXT_END  = 3'd4
    } t_func;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic start_key;
        logic key_byte;
        logic fill_begin;
        logic fill_step;
        logic text_byte;
        logic text_end;
        logic cell_read;
        logic emit;
    } t_dp_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic letter_ok;
        logic held_vld;
        logic walk_last;
        logic out_free;
    } t_dp_sts;

    typedef struct packed {
        logic       ok;
        logic [4:0] idx;
    } t_letter;

    typedef struct packed {
        logic [2:0] row;
        logic [2:0] col;
    } t_pos;

    // Byte to letter index, case folded, J folded into I
    function automatic t_letter clean_letter(input logic [7:0] sym);
        t_letter res;
        res.ok  = 1'b0;
        res.idx = 5'd0;
        if (sym >= ASCII_UP_A && sym <= ASCII_UP_Z) begin
            res.ok  = 1'b1;
            res.idx = 5'(sym - ASCII_UP_A);
        end else if (sym >= ASCII_LO_A && sym <= ASCII_LO_Z) begin
            res.ok  = 1'b1;
            res.idx = 5'(sym - ASCII_LO_A);
        end
        if (res.idx == LETTER_J) begin
            res.idx = LETTER_I;
        end
        return res;
    endfunction

    // Cell number to row and column
    function automatic t_pos cell_pos(input logic [4:0] place);
        logic [4:0] pm;
        t_pos       res;
        pm = (place >= CELL_COUNT) ? 5'(place - CELL_COUNT) : place;
        if (pm >= 5'd20)      res.row = 3'd4;
        else if (pm >= 5'd15) res.row = 3'd3;
        else if (pm >= 5'd10) res.row = 3'd2;
        else if (pm >= 5'd5)  res.row = 3'd1;
        else                  res.row = 3'd0;
        res.col = 3'(pm - ({res.row, 2'b00} + {2'b00, res.row}));
        return res;
    endfunction

    // One step around a row or column, forward or backward
    function automatic logic [2:0] wrap_step(input logic [2:0] v, input logic fwd);
        logic [2:0] res;
        if (fwd) res = (v == 3'd4) ? 3'd0 : 3'(v + 3'd1);
        else     res = (v == 3'd0) ? 3'd4 : 3'(v - 3'd1);
        return res;
    endfunction

    function automatic logic [4:0] cell_addr(input logic [2:0] row, input logic [2:0] col);
        return 5'({row, 2'b00}) + 5'(row) + 5'(col);
    endfunction

endpackage

`default_nettype wire

### design/pfc_ram.sv
`timescale 1ns / 1ps
`default_nettype none

// Simple RAM: one write port, two registered read ports
module pfc_ram #(
    parameter int WIDTH = 5,
    parameter int DEPTH = 25
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic      [WIDTH-1:0]         o_rdata_a,
    output logic      [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rdata_a <= r_mem[i_raddr_a];
            o_rdata_b <= r_mem[i_raddr_b];
        end
    end

endmodule

`default_nettype wire

### design/pfc_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module pfc_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_s_tvalid,
    output logic                 o_s_tready,
    input  wire logic [2:0]      i_func,
    input  wire pfc_pkg::t_dp_sts i_sts,
    output pfc_pkg::t_dp_cmd     o_cmd
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_FILL = 4'b0010,
        ST_CELL = 4'b0100,
        ST_EMIT = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_s_tready = (r_state == ST_IDLE);

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_s_tvalid) begin
                    unique case (pfc_pkg::t_func'(i_func))
                        pfc_pkg::FUNC_START_KEY: begin
                            o_cmd.start_key = 1'b1;
                        end
                        pfc_pkg::FUNC_KEY_BYTE: begin
                            o_cmd.key_byte = 1'b1;
                        end
                        pfc_pkg::FUNC_KEY_END: begin
                            o_cmd.fill_begin = 1'b1;
                            n_state          = ST_FILL;
                        end
                        pfc_pkg::FUNC_TEXT_BYTE: begin
                            o_cmd.text_byte = 1'b1;
                            if (i_sts.letter_ok && i_sts.held_vld) begin
                                n_state = ST_CELL;
                            end
                        end
                        pfc_pkg::FUNC_TEXT_END: begin
                            o_cmd.text_end = 1'b1;
                            n_state = i_sts.held_vld ? ST_CELL : ST_EMIT;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_FILL: begin
                o_cmd.fill_step = 1'b1;
                if (i_sts.walk_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_CELL: begin
                o_cmd.cell_read = 1'b1;
                n_state         = ST_EMIT;
            end
            ST_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

### design/pfc_dpath.sv
`timescale 1ns / 1ps
`default_nettype none

module pfc_dpath (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire pfc_pkg::t_dp_cmd i_cmd,
    output pfc_pkg::t_dp_sts      o_sts,
    input  wire logic [7:0]       i_symbol,
    input  wire logic             i_cfg_we,
    input  wire logic             i_cfg_wdata,
    output logic                  o_out_vld,
    input  wire logic             i_out_rdy,
    output logic [6:0]            o_first_char,
    output logic [6:0]            o_second_char,
    output logic                  o_has_pair,
    output logic                  o_last
);

    logic                  r_mode;
    logic [25:0]           r_used;
    logic [4:0]            r_fill;
    logic [4:0]            r_walk;
    logic [4:0]            r_held;
    logic                  r_held_vld;
    logic                  r_last;
    logic                  r_has_pair;
    logic                  r_out_vld;
    logic [6:0]            r_first;
    logic [6:0]            r_second;

    pfc_pkg::t_letter      w_in;
    logic                  w_key_new;
    logic                  w_walk_new;
    logic                  w_walk_last;
    logic                  w_wr;
    logic [4:0]            w_letter;
    logic [4:0]            w_pair_b;
    logic                  w_place_rd;
    logic [4:0]            w_place_a;
    logic [4:0]            w_place_b;
    logic [4:0]            w_sq_a;
    logic [4:0]            w_sq_b;
    pfc_pkg::t_pos         w_pos_a;
    pfc_pkg::t_pos         w_pos_b;
    logic [4:0]            w_q_a;
    logic [4:0]            w_q_b;

    assign w_in       = pfc_pkg::clean_letter(i_symbol);
    assign w_key_new  = w_in.ok && !r_used[w_in.idx] && (r_fill < pfc_pkg::CELL_COUNT);
    assign w_walk_new = !r_used[r_walk] && (r_fill < pfc_pkg::CELL_COUNT);
    assign w_walk_last = (r_walk == pfc_pkg::LAST_LETTER);

    // Key square and letter place writes share one letter/cell pair
    assign w_wr     = (i_cmd.key_byte && w_key_new) || (i_cmd.fill_step && w_walk_new);
    assign w_letter = i_cmd.fill_step ? r_walk : w_in.idx;

    // Pair lookup: held letter against new letter, X on a double or at text end
    assign w_pair_b   = (i_cmd.text_end || (r_held == w_in.idx)) ? pfc_pkg::LETTER_X
                                                                 : w_in.idx;
    assign w_place_rd = i_cmd.text_byte || i_cmd.text_end;

    pfc_ram #(
        .WIDTH (5),
        .DEPTH (pfc_pkg::LETTERS)
    ) u_place_ram (
        .i_clk     (i_clk),
        .i_we      (w_wr),
        .i_waddr   (w_letter),
        .i_wdata   (r_fill),
        .i_rd_en   (w_place_rd),
        .i_raddr_a (r_held),
        .i_raddr_b (w_pair_b),
        .o_rdata_a (w_place_a),
        .o_rdata_b (w_place_b)
    );

    // Substitution rules on the looked-up cells
    assign w_pos_a = pfc_pkg::cell_pos(w_place_a);
    assign w_pos_b = pfc_pkg::cell_pos(w_place_b);

    always_comb begin
        if (w_pos_a.row == w_pos_b.row) begin
            w_q_a = pfc_pkg::cell_addr(w_pos_a.row, pfc_pkg::wrap_step(w_pos_a.col, r_mode));
            w_q_b = pfc_pkg::cell_addr(w_pos_b.row, pfc_pkg::wrap_step(w_pos_b.col, r_mode));
        end else if (w_pos_a.col == w_pos_b.col) begin
            w_q_a = pfc_pkg::cell_addr(pfc_pkg::wrap_step(w_pos_a.row, r_mode), w_pos_a.col);
            w_q_b = pfc_pkg::cell_addr(pfc_pkg::wrap_step(w_pos_b.row, r_mode), w_pos_b.col);
        end else begin
            w_q_a = pfc_pkg::cell_addr(w_pos_a.row, w_pos_b.col);
            w_q_b = pfc_pkg::cell_addr(w_pos_b.row, w_pos_a.col);
        end
    end

    pfc_ram #(
        .WIDTH (5),
        .DEPTH (pfc_pkg::CELLS)
    ) u_square_ram (
        .i_clk     (i_clk),
        .i_we      (w_wr),
        .i_waddr   (r_fill),
        .i_wdata   (w_letter),
        .i_rd_en   (i_cmd.cell_read),
        .i_raddr_a (w_q_a),
        .i_raddr_b (w_q_b),
        .o_rdata_a (w_sq_a),
        .o_rdata_b (w_sq_b)
    );

    // Mode, key state and held letter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= 1'b1;
            r_used     <= 26'(1) << pfc_pkg::LETTER_J;
            r_fill     <= '0;
            r_walk     <= '0;
            r_held     <= '0;
            r_held_vld <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_mode <= i_cfg_wdata;
            end
            if (i_cmd.start_key) begin
                r_used     <= 26'(1) << pfc_pkg::LETTER_J;
                r_fill     <= '0;
                r_held     <= '0;
                r_held_vld <= 1'b0;
            end else if (i_cmd.fill_step && w_walk_last) begin
                r_used <= '1;
            end else if (w_wr) begin
                r_used[w_letter] <= 1'b1;
            end
            if (w_wr) begin
                r_fill <= 5'(r_fill + 5'd1);
            end
            if (i_cmd.fill_begin) begin
                r_walk <= '0;
            end else if (i_cmd.fill_step) begin
                r_walk <= 5'(r_walk + 5'd1);
            end
            if (i_cmd.text_byte && w_in.ok) begin
                if (!r_held_vld) begin
                    r_held     <= w_in.idx;
                    r_held_vld <= 1'b1;
                end else if (r_held != w_in.idx) begin
                    r_held_vld <= 1'b0;
                end
            end
            if (i_cmd.text_end) begin
                r_held_vld <= 1'b0;
            end
        end
    end

    // Result kind, fixed when the item is taken
    always_ff @(posedge i_clk) begin
        if (i_cmd.text_byte) begin
            r_last     <= 1'b0;
            r_has_pair <= 1'b1;
        end else if (i_cmd.text_end) begin
            r_last     <= 1'b1;
            r_has_pair <= r_held_vld;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_vld <= 1'b1;
        end else if (i_out_rdy) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_first  <= r_has_pair ? 7'(pfc_pkg::CHAR_A + {2'b00, w_sq_a}) : 7'd0;
            r_second <= r_has_pair ? 7'(pfc_pkg::CHAR_A + {2'b00, w_sq_b}) : 7'd0;
            o_has_pair <= r_has_pair;
            o_last     <= r_last;
        end
    end

    assign o_out_vld     = r_out_vld;
    assign o_first_char  = r_first;
    assign o_second_char = r_second;

    assign o_sts.letter_ok = w_in.ok;
    assign o_sts.held_vld  = r_held_vld;
    assign o_sts.walk_last = w_walk_last;
    assign o_sts.out_free  = !r_out_vld || i_out_rdy;

endmodule

`default_nettype wire

### design/playfair_digram_cipher.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel  | Dir | tdata (low bit up)                   | tuser     | tlast
// s_axis   | in  | symbol[7:0]                          | func[2:0] | -
// m_axis   | out | first_char[6:0], second_char[13:7]   | has_pair  | last
// cfg      | in  | i_cfg_wdata = encrypt_mode, written when i_cfg_we is high
//
// Start key, key byte, an unused code and a text byte that forms no pair need only the accept state.
// Key end takes the accept state, then the fill walk over 26 letters.
// A text pair or a text end with a held letter goes through place read, square read and
// output load; a text end with no held letter goes straight to output load. Reset is synchronous, active low.
// A result waits in the output register while the next item is taken; a new result
// stalls in its last cycle until that register is free.
module playfair_digram_cipher (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // symbol[7:0]
    input  wire logic [2:0]  s_axis_tuser,   // func[2:0]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,   // first_char[6:0], second_char[13:7], zero
    output logic [0:0]       m_axis_tuser,   // has_pair
    output logic             m_axis_tlast,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_wdata
);

    pfc_pkg::t_dp_cmd w_cmd;
    pfc_pkg::t_dp_sts w_sts;
    logic [6:0]       w_first;
    logic [6:0]       w_second;
    logic             w_has_pair;

    pfc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .i_func     (s_axis_tuser),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    pfc_dpath u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_symbol      (s_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .o_out_vld     (m_axis_tvalid),
        .i_out_rdy     (m_axis_tready),
        .o_first_char  (w_first),
        .o_second_char (w_second),
        .o_has_pair    (w_has_pair),
        .o_last        (m_axis_tlast)
    );

    assign m_axis_tdata = {2'b00, w_second, w_first};
    assign m_axis_tuser = w_has_pair;

endmodule

`default_nettype wire
